### src/mlk_pkg.sv
// package for the morse letter keyer: phase codes, register indexes,
// result record and the letter code table; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mlk_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LIT  = 2'd1,
        PH_DARK = 2'd2
    } phase_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNIT_TICKS       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DASH_UNITS       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LETTER_GAP_UNITS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLANK_UNITS      = 2'd3;

    localparam logic [15:0] UNIT_TICKS_RST       = 16'd500;
    localparam logic [3:0]  DASH_UNITS_RST       = 4'd3;
    localparam logic [3:0]  LETTER_GAP_UNITS_RST = 4'd3;
    localparam logic [3:0]  BLANK_UNITS_RST      = 4'd2;

    localparam logic [7:0] CHAR_A = 8'd65;
    localparam logic [7:0] CHAR_Z = 8'd90;

    typedef struct packed {
        logic lamp_on;
        logic busy_res;
        logic accepted;
    } res_t;

    typedef struct packed {
        logic [2:0] len;
        logic [3:0] bits;
    } letter_code_t;

    // element count and pattern per letter, first element in bit 0, 1 = dash
    function automatic letter_code_t letter_code(input logic [4:0] k);
        letter_code_t c;
        case (k)
            5'd0:    c = '{3'd2, 4'd2};
            5'd1:    c = '{3'd4, 4'd1};
            5'd2:    c = '{3'd4, 4'd5};
            5'd3:    c = '{3'd3, 4'd1};
            5'd4:    c = '{3'd1, 4'd0};
            5'd5:    c = '{3'd4, 4'd4};
            5'd6:    c = '{3'd3, 4'd3};
            5'd7:    c = '{3'd4, 4'd0};
            5'd8:    c = '{3'd2, 4'd0};
            5'd9:    c = '{3'd4, 4'd14};
            5'd10:   c = '{3'd3, 4'd5};
            5'd11:   c = '{3'd4, 4'd2};
            5'd12:   c = '{3'd2, 4'd3};
            5'd13:   c = '{3'd2, 4'd1};
            5'd14:   c = '{3'd3, 4'd7};
            5'd15:   c = '{3'd4, 4'd6};
            5'd16:   c = '{3'd4, 4'd11};
            5'd17:   c = '{3'd3, 4'd2};
            5'd18:   c = '{3'd3, 4'd0};
            5'd19:   c = '{3'd1, 4'd1};
            5'd20:   c = '{3'd3, 4'd4};
            5'd21:   c = '{3'd4, 4'd8};
            5'd22:   c = '{3'd3, 4'd6};
            5'd23:   c = '{3'd4, 4'd9};
            5'd24:   c = '{3'd4, 4'd13};
            5'd25:   c = '{3'd4, 4'd3};
            default: c = '{3'd1, 4'd0};
        endcase
        return c;
    endfunction

    function automatic logic [3:0] at_least_one(input logic [3:0] v);
        return (v == 4'd0) ? 4'd1 : v;
    endfunction

endpackage

`default_nettype wire

### src/morse_letter_keyer.sv
// morse letter keyer top level: keying state machine, config registers
// and a two-entry result queue; depends on mlk_pkg
//
// channel   dir  handshake              payload
// in        in   in_valid / in_ready    operation, character
// out       out  out_valid / out_ready  lamp_on, busy_res, accepted
// cfg       in   cfg_we                 cfg_index, cfg_data
//
// one item per cycle while in_ready is high: each item updates the keying
// state in the cycle it is accepted, and its result is registered
// results wait in an output register plus one skid entry; in_ready drops
// only while both are full
// reset puts the keyer in idle with config at its default values
`timescale 1ns / 1ps
`default_nettype none

module morse_letter_keyer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           operation,
    input  wire logic [7:0]                     character,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                lamp_on,
    output logic                                busy_res,
    output logic                                accepted,
    input  wire logic                           cfg_we,
    input  wire logic [mlk_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mlk_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mlk_pkg::*;

    logic [15:0] unit_ticks_reg;
    logic [3:0]  dash_units_reg;
    logic [3:0]  letter_gap_units_reg;
    logic [3:0]  blank_units_reg;

    phase_t      phase_reg, phase_next;
    logic [3:0]  element_pattern_reg, element_pattern_next;
    logic [2:0]  elements_left_reg, elements_left_next;
    logic [15:0] tick_count_reg, tick_count_next;
    logic [3:0]  units_left_reg, units_left_next;

    res_t        out_data_reg, skid_data_reg, res_new;
    logic        out_valid_reg, skid_valid_reg;

    logic        in_accept, out_pop;
    logic [16:0] tick_sum;
    logic [3:0]  units_dec;
    logic [4:0]  letter_idx;
    letter_code_t code;
    logic        is_letter;

    assign in_ready  = !skid_valid_reg;
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_pop   = out_valid_reg && out_ready;
    assign lamp_on   = out_data_reg.lamp_on;
    assign busy_res  = out_data_reg.busy_res;
    assign accepted  = out_data_reg.accepted;

    assign letter_idx = 5'(character - CHAR_A);
    assign code       = letter_code(letter_idx);
    assign is_letter  = (character >= CHAR_A) && (character <= CHAR_Z);
    assign tick_sum   = {1'b0, tick_count_reg} + 17'd1;
    assign units_dec  = units_left_reg - 4'd1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg       <= UNIT_TICKS_RST;
            dash_units_reg       <= DASH_UNITS_RST;
            letter_gap_units_reg <= LETTER_GAP_UNITS_RST;
            blank_units_reg      <= BLANK_UNITS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UNIT_TICKS:       unit_ticks_reg       <= cfg_data;
                CFG_DASH_UNITS:       dash_units_reg       <= cfg_data[3:0];
                CFG_LETTER_GAP_UNITS: letter_gap_units_reg <= cfg_data[3:0];
                CFG_BLANK_UNITS:      blank_units_reg      <= cfg_data[3:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_IDLE;
            element_pattern_reg <= 4'd0;
            elements_left_reg   <= 3'd0;
            tick_count_reg      <= 16'd0;
            units_left_reg      <= 4'd0;
        end
        else if (in_accept)
        begin
            phase_reg           <= phase_next;
            element_pattern_reg <= element_pattern_next;
            elements_left_reg   <= elements_left_next;
            tick_count_reg      <= tick_count_next;
            units_left_reg      <= units_left_next;
        end
    end

    always_comb
    begin
        phase_t cur;
        cur                  = phase_reg;
        phase_next           = phase_reg;
        element_pattern_next = element_pattern_reg;
        elements_left_next   = elements_left_reg;
        tick_count_next      = tick_count_reg;
        units_left_next      = units_left_reg;
        res_new.accepted     = 1'b0;

        unique case (phase_reg)
            PH_LIT, PH_DARK: cur = phase_reg;
            default:         cur = PH_IDLE;
        endcase
        phase_next = cur;

        if (!operation)
        begin
            if (cur == PH_IDLE)
            begin
                res_new.accepted = 1'b1;
                tick_count_next  = 16'd0;
                if (is_letter)
                begin
                    // first element starts on the load item
                    phase_next           = PH_LIT;
                    units_left_next      = code.bits[0] ? at_least_one(dash_units_reg) : 4'd1;
                    element_pattern_next = {1'b0, code.bits[3:1]};
                    elements_left_next   = code.len - 3'd1;
                end
                else
                begin
                    phase_next           = PH_DARK;
                    units_left_next      = at_least_one(blank_units_reg);
                    element_pattern_next = 4'd0;
                    elements_left_next   = 3'd0;
                end
            end
        end
        else if (cur != PH_IDLE)
        begin
            if (tick_sum >= {1'b0, unit_ticks_reg})
            begin
                tick_count_next = 16'd0;
                units_left_next = units_dec;
                if (units_dec == 4'd0)
                begin
                    if (cur == PH_LIT)
                    begin
                        phase_next      = PH_DARK;
                        units_left_next = (elements_left_reg != 3'd0) ? 4'd1
                                        : at_least_one(letter_gap_units_reg);
                    end
                    else if (elements_left_reg != 3'd0)
                    begin
                        elements_left_next   = elements_left_reg - 3'd1;
                        phase_next           = PH_LIT;
                        units_left_next      = element_pattern_reg[0]
                                             ? at_least_one(dash_units_reg) : 4'd1;
                        element_pattern_next = {1'b0, element_pattern_reg[3:1]};
                    end
                    else
                    begin
                        phase_next           = PH_IDLE;
                        element_pattern_next = 4'd0;
                    end
                end
            end
            else
            begin
                tick_count_next = tick_sum[15:0];
            end
        end

        res_new.lamp_on  = (phase_next == PH_LIT);
        res_new.busy_res = (phase_next != PH_IDLE);
    end

    // result queue: output register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_accept)
        begin
            if (!out_valid_reg || out_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (in_accept)
        begin
            if (!out_valid_reg || out_pop)
            begin
                out_data_reg <= res_new;
            end
            else
            begin
                skid_data_reg <= res_new;
            end
        end
    end

    // skid entry only fills behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // an active phase always has a unit left to run
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LIT || phase_reg == PH_DARK) |-> units_left_reg != 4'd0)
        else $error("active phase with no units left");

    // a taken load always leaves the keyer busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !operation && phase_reg == PH_IDLE) |=> phase_reg != PH_IDLE)
        else $error("load taken but keyer not busy");

endmodule

`default_nettype wire
